// File: hw/rtl/rmts_pkg.sv
// ----------------------------------------------------------------------------
// Rate monotonic tick scheduler package
// Shared constants, register codes and types for the scheduler modules.
// ----------------------------------------------------------------------------
package rmts_pkg;

  localparam int MAX_TASKS       = 8;
  localparam int TIME_BITS       = 16;
  localparam int TASK_IDX_BITS   = 3;
  localparam int TASK_COUNT_BITS = 4;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 64;
  localparam int FIELD_BITS      = 16;

  // Result queue geometry.
  localparam int OQ_DEPTH    = 4;
  localparam int OQ_PTR_BITS = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_BITS = $clog2(OQ_DEPTH + 1);

  typedef logic [TIME_BITS-1:0]     tick_t;
  typedef logic [TASK_IDX_BITS-1:0] task_idx_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TASK_COUNT   = 3'd0,
    CFG_HYPER_PERIOD = 3'd1,
    CFG_PERIODS_LO   = 3'd2,
    CFG_PERIODS_HI   = 3'd3,
    CFG_BURSTS_LO    = 3'd4,
    CFG_BURSTS_HI    = 3'd5
  } cfg_reg_t;

  // Best candidate handed from one task cell to the next.
  typedef struct packed {
    logic      valid;
    tick_t     period;
    task_idx_t idx;
  } best_t;

  // Per-tick control broadcast to every task cell.
  typedef struct packed {
    logic      tick;
    logic      clear;
    logic      sel_valid;
    task_idx_t sel_idx;
  } cell_ctrl_t;

  // One result item.
  typedef struct packed {
    logic      is_idle;
    task_idx_t task_index;
    tick_t     interval_start;
    tick_t     interval_end;
    logic      round_end;
    logic      last_result;
  } result_t;

endpackage

// File: hw/rtl/rmts_cell.sv
// ----------------------------------------------------------------------------
// Rate monotonic task cell
// Holds one task's release countdown and remaining burst, and passes the
// best ready candidate so far along the chain.
// ----------------------------------------------------------------------------
module rmts_cell
  import rmts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  task_idx_t  cell_idx,
  input  logic       en,
  input  tick_t      burst_cfg,
  input  tick_t      period_eff,
  input  best_t      best_in,
  output best_t      best_out
);

  tick_t rb_r, rb_nxt;
  tick_t cd_r, cd_nxt;
  tick_t rb_rel;
  logic  ready;
  logic  selected;

  // Remaining burst after this tick's release, before the run decrement.
  assign rb_rel   = (cd_r == '0) ? burst_cfg : rb_r;
  assign ready    = en && (rb_rel != '0);
  assign selected = ctrl.sel_valid && (ctrl.sel_idx == cell_idx);

  always_comb begin
    best_out = best_in;
    if (ready && (!best_in.valid || (period_eff < best_in.period))) begin
      best_out.valid  = 1'b1;
      best_out.period = period_eff;
      best_out.idx    = cell_idx;
    end
  end

  always_comb begin
    rb_nxt = rb_r;
    cd_nxt = cd_r;
    if (ctrl.clear) begin
      rb_nxt = '0;
      cd_nxt = '0;
    end else if (ctrl.tick && en) begin
      rb_nxt = selected ? (rb_rel - tick_t'(1)) : rb_rel;
      cd_nxt = (cd_r == '0) ? (period_eff - tick_t'(1)) : (cd_r - tick_t'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_r <= '0;
      cd_r <= '0;
    end else begin
      rb_r <= rb_nxt;
      cd_r <= cd_nxt;
    end
  end

endmodule

// File: hw/rtl/rmts_out_fifo.sv
// ----------------------------------------------------------------------------
// Rate monotonic result queue
// Small queue that takes up to two result items per cycle and hands out one per cycle while the reader is ready.
// ----------------------------------------------------------------------------
module rmts_out_fifo
  import rmts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  push_cnt,
  input  result_t     push_a,
  input  result_t     push_b,
  output logic        space_ok,
  output logic        pop_valid,
  input  logic        pop_ready,
  output result_t     pop_data
);

  result_t                mem_r [OQ_DEPTH];
  logic [OQ_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CNT_BITS-1:0] count_r, count_nxt;
  logic                   pop;
  logic [OQ_PTR_BITS-1:0] wr_ptr_b;

  // Room for the worst case of two results from one tick.
  assign space_ok  = count_r <= OQ_CNT_BITS'(OQ_DEPTH - 2);
  assign pop_valid = count_r != '0;
  assign pop_data  = mem_r[rd_ptr_r];
  assign pop       = pop_valid && pop_ready;
  assign wr_ptr_b  = wr_ptr_r + OQ_PTR_BITS'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OQ_PTR_BITS'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + OQ_PTR_BITS'(pop);
    count_nxt  = count_r + OQ_CNT_BITS'(push_cnt) - OQ_CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push_a;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_b] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: hw/rtl/rate_monotonic_tick_scheduler_top.sv
// ----------------------------------------------------------------------------
// Rate monotonic tick scheduler, top level
// Results of an accepted tick item are written into the result queue and
// are presented on out_ from there; a tick's second result follows its first.
// Throughput: one tick item per clock through the combinational task cell
// chain; input stalls only while the four-entry result queue has fewer than
// two free slots. Reset (synchronous, rst_n low) restores the default
// configuration, clears the round state and empties the queue.
// ----------------------------------------------------------------------------
module rate_monotonic_tick_scheduler_top
  import rmts_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_restart,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_is_idle,
  output logic [2:0]               out_task_index,
  output logic [15:0]              out_interval_start,
  output logic [15:0]              out_interval_end,
  output logic                     out_round_end,
  output logic                     out_last_result
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; indexes past the
  // register list are ignored.
  // --------------------------------------------------------------------------
  logic [TASK_COUNT_BITS-1:0] task_count_r;
  tick_t                      hyper_period_r;
  logic [CFG_DATA_BITS-1:0]   periods_lo_r, periods_hi_r;
  logic [CFG_DATA_BITS-1:0]   bursts_lo_r, bursts_hi_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r   <= TASK_COUNT_BITS'(1);
      hyper_period_r <= tick_t'(1);
      periods_lo_r   <= 64'h0001_0001_0001_0001;
      periods_hi_r   <= 64'h0001_0001_0001_0001;
      bursts_lo_r    <= '0;
      bursts_hi_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TASK_COUNT:   task_count_r   <= cfg_data[TASK_COUNT_BITS-1:0];
        CFG_HYPER_PERIOD: hyper_period_r <= cfg_data[TIME_BITS-1:0];
        CFG_PERIODS_LO:   periods_lo_r   <= cfg_data;
        CFG_PERIODS_HI:   periods_hi_r   <= cfg_data;
        CFG_BURSTS_LO:    bursts_lo_r    <= cfg_data;
        CFG_BURSTS_HI:    bursts_hi_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // A task count of zero acts as one; counts above the cell row saturate.
  logic [TASK_COUNT_BITS-1:0] n_eff;
  always_comb begin
    if (task_count_r == '0) begin
      n_eff = TASK_COUNT_BITS'(1);
    end else if (task_count_r > TASK_COUNT_BITS'(MAX_TASKS)) begin
      n_eff = TASK_COUNT_BITS'(MAX_TASKS);
    end else begin
      n_eff = task_count_r;
    end
  end

  // --------------------------------------------------------------------------
  // Round state: time, the running task and where its segment began.
  // --------------------------------------------------------------------------
  tick_t     time_r, time_nxt;
  logic      run_valid_r, run_valid_nxt;
  task_idx_t run_task_r, run_task_nxt;
  tick_t     seg_r, seg_nxt;

  logic       accept;
  logic       tick;
  logic       space_ok;
  cell_ctrl_t ctrl;
  best_t      best_chain [MAX_TASKS+1];

  assign in_ready = space_ok;
  assign accept   = in_valid && in_ready;
  assign tick     = accept && !in_restart;

  // --------------------------------------------------------------------------
  // Task cell chain. Cell 0 sees an empty candidate; each cell replaces the
  // candidate only with a strictly shorter period, so ties stay with the
  // lowest index. The winner at the end of the chain runs this tick.
  // --------------------------------------------------------------------------
  logic [2*CFG_DATA_BITS-1:0] periods_all, bursts_all;
  assign periods_all   = {periods_hi_r, periods_lo_r};
  assign bursts_all    = {bursts_hi_r, bursts_lo_r};
  assign best_chain[0] = '0;

  for (genvar gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
    tick_t period_raw;
    tick_t period_eff;
    tick_t burst_cfg;
    logic  en;

    assign period_raw = periods_all[gi*FIELD_BITS +: TIME_BITS];
    assign period_eff = (period_raw == '0) ? tick_t'(1) : period_raw;
    assign burst_cfg  = bursts_all[gi*FIELD_BITS +: TIME_BITS];
    assign en         = n_eff >= TASK_COUNT_BITS'(gi + 1);

    rmts_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .cell_idx   (task_idx_t'(gi)),
      .en         (en),
      .burst_cfg  (burst_cfg),
      .period_eff (period_eff),
      .best_in    (best_chain[gi]),
      .best_out   (best_chain[gi+1])
    );
  end

  // --------------------------------------------------------------------------
  // Interval bookkeeping for the tick.
  // --------------------------------------------------------------------------
  logic      sel_valid;
  task_idx_t sel_idx;
  logic      change;
  logic      r1_fire;
  logic      round_done;
  tick_t     next_time;
  tick_t     hp_eff;
  result_t   res_switch, res_round;
  result_t   push_a, push_b;
  logic [1:0] push_cnt;

  assign sel_valid = best_chain[MAX_TASKS].valid;
  assign sel_idx   = best_chain[MAX_TASKS].idx;
  assign change    = (sel_valid != run_valid_r) ||
                     (sel_valid && (sel_idx != run_task_r));
  // An idle stretch that covered no ticks is not reported.
  assign r1_fire   = change && (run_valid_r || (time_r > seg_r));

  assign next_time  = time_r + tick_t'(1);
  assign hp_eff     = (hyper_period_r == '0) ? tick_t'(1) : hyper_period_r;
  // The round also ends if the time counter would wrap.
  assign round_done = (next_time == '0) || (next_time >= hp_eff);

  always_comb begin
    seg_nxt       = seg_r;
    run_valid_nxt = run_valid_r;
    run_task_nxt  = run_task_r;
    if (change) begin
      seg_nxt       = time_r;
      run_valid_nxt = sel_valid;
      run_task_nxt  = sel_valid ? sel_idx : '0;
    end
  end

  always_comb begin
    res_switch.is_idle        = !run_valid_r;
    res_switch.task_index     = run_valid_r ? run_task_r : '0;
    res_switch.interval_start = seg_r;
    res_switch.interval_end   = time_r;
    res_switch.round_end      = 1'b0;
    res_switch.last_result    = !round_done;

    res_round.is_idle         = !run_valid_nxt;
    res_round.task_index      = run_valid_nxt ? run_task_nxt : '0;
    res_round.interval_start  = seg_nxt;
    res_round.interval_end    = next_time;
    res_round.round_end       = 1'b1;
    res_round.last_result     = 1'b1;

    push_a   = r1_fire ? res_switch : res_round;
    push_b   = res_round;
    push_cnt = 2'd0;
    if (tick) begin
      push_cnt = {1'b0, r1_fire} + {1'b0, round_done};
    end
  end

  // Cells clear on a restart item and at the end of a round.
  always_comb begin
    ctrl.tick      = tick;
    ctrl.clear     = accept && (in_restart || round_done);
    ctrl.sel_valid = sel_valid;
    ctrl.sel_idx   = sel_idx;
  end

  always_comb begin
    time_nxt = time_r;
    if (accept) begin
      if (in_restart || round_done) begin
        time_nxt = '0;
      end else begin
        time_nxt = next_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      run_valid_r <= 1'b0;
      run_task_r  <= '0;
      seg_r       <= '0;
    end else begin
      time_r <= time_nxt;
      if (accept) begin
        if (in_restart || round_done) begin
          run_valid_r <= 1'b0;
          run_task_r  <= '0;
          seg_r       <= '0;
        end else begin
          run_valid_r <= run_valid_nxt;
          run_task_r  <= run_task_nxt;
          seg_r       <= seg_nxt;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result queue. It decouples the output side, so ticks keep flowing while
  // a finished result waits to be taken, as long as two slots stay free.
  // --------------------------------------------------------------------------
  result_t pop_data;

  rmts_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_a    (push_a),
    .push_b    (push_b),
    .space_ok  (space_ok),
    .pop_valid (out_valid),
    .pop_ready (out_ready),
    .pop_data  (pop_data)
  );

  assign out_is_idle        = pop_data.is_idle;
  assign out_task_index     = pop_data.task_index;
  assign out_interval_start = pop_data.interval_start;
  assign out_interval_end   = pop_data.interval_end;
  assign out_round_end      = pop_data.round_end;
  assign out_last_result    = pop_data.last_result;

endmodule

// File: hw/rtl/rmts_checker.sv
// ----------------------------------------------------------------------------
// Rate monotonic scheduler port checker
// Watches the top level's ports and flags results that break the schedule.
// ----------------------------------------------------------------------------
module rmts_checker
  import rmts_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     out_is_idle,
  input logic [2:0]               out_task_index,
  input logic [15:0]              out_interval_start,
  input logic [15:0]              out_interval_end,
  input logic                     out_round_end,
  input logic                     out_last_result
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_interval_start) &&
      $stable(out_interval_end) && $stable(out_task_index))
    else $error("result changed while stalled");

  // The round-closing result is always the last one of its tick.
  a_round_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_round_end |-> out_last_result)
    else $error("round end result not marked last");

  // Idle intervals report task zero.
  a_idle_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_idle |-> out_task_index == 3'd0)
    else $error("idle interval carries a task index");

  // Intervals closed by a task switch cover at least one tick.
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_round_end |-> out_interval_start < out_interval_end)
    else $error("empty switch interval");

endmodule

bind rate_monotonic_tick_scheduler_top rmts_checker u_rmts_checker (.*);
